@@ hw/rtl/fdc_pkg.sv @@
package fdc_pkg;

  localparam int unsigned DATA_W     = 80;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned MAX_PAYLOAD_DEFAULT = 256;

  localparam logic [POS_W-1:0] HDR_LEN  = 17'd11;
  localparam logic [POS_W-1:0] CRC_SPAN = 17'd9;
  localparam logic [POS_W-1:0] POS_MAX  = 17'h1FFFF;
  localparam logic [15:0]      CRC_POLY = 16'h1021;

  // Header byte positions
  localparam logic [POS_W-1:0] POS_MAGIC0  = 17'd0;
  localparam logic [POS_W-1:0] POS_MAGIC1  = 17'd1;
  localparam logic [POS_W-1:0] POS_VERSION = 17'd2;
  localparam logic [POS_W-1:0] POS_TYPE    = 17'd3;
  localparam logic [POS_W-1:0] POS_FLAGS   = 17'd4;
  localparam logic [POS_W-1:0] POS_SEQ_LO  = 17'd5;
  localparam logic [POS_W-1:0] POS_SEQ_HI  = 17'd6;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd7;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd8;
  localparam logic [POS_W-1:0] POS_CRC_LO  = 17'd9;
  localparam logic [POS_W-1:0] POS_CRC_HI  = 17'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_FIRST  = 3'd0,
    CFG_MAGIC_SECOND = 3'd1,
    CFG_VERSION      = 3'd2,
    CFG_CRC_SEED     = 3'd3,
    CFG_MAX_LEN      = 3'd4,
    CFG_TYPE_MASK    = 3'd5,
    CFG_UNKNOWN_TYPE = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_CRC_ERR   = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  protocol_version;
    logic [15:0] crc_seed;
    logic [15:0] max_payload_len;
    logic [63:0] known_type_mask;
    logic [7:0]  unknown_type_code;
  } cfg_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  payload_value;
    logic [15:0] payload_offset;
    logic [2:0]  status_code;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] sequence_number;
    logic [15:0] payload_count;
    logic        run_last;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/fdc_cfg_regs.sv @@
module fdc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fdc_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first       <= 8'h00;
      cfg.magic_second      <= 8'h00;
      cfg.protocol_version  <= 8'h00;
      cfg.crc_seed          <= 16'hFFFF;
      cfg.max_payload_len   <= 16'd256;
      cfg.known_type_mask   <= 64'h0;
      cfg.unknown_type_code <= 8'h00;
    end else if (cfg_valid) begin
      unique case (fdc_pkg::cfg_index_t'(cfg_index))
        fdc_pkg::CFG_MAGIC_FIRST:  cfg.magic_first       <= cfg_data[7:0];
        fdc_pkg::CFG_MAGIC_SECOND: cfg.magic_second      <= cfg_data[7:0];
        fdc_pkg::CFG_VERSION:      cfg.protocol_version  <= cfg_data[7:0];
        fdc_pkg::CFG_CRC_SEED:     cfg.crc_seed          <= cfg_data[15:0];
        fdc_pkg::CFG_MAX_LEN:      cfg.max_payload_len   <= cfg_data[15:0];
        fdc_pkg::CFG_TYPE_MASK:    cfg.known_type_mask   <= cfg_data;
        fdc_pkg::CFG_UNKNOWN_TYPE: cfg.unknown_type_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/fdc_decoder.sv @@
module fdc_decoder #(
  parameter int unsigned MAX_PAYLOAD = fdc_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  fdc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              room,
  output logic              push_a,
  output fdc_pkg::result_t  res_a,
  output logic              push_b,
  output fdc_pkg::result_t  res_b
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  // input register
  logic        held_valid;
  logic [7:0]  held_byte;
  logic        held_last;

  // frame state
  logic [fdc_pkg::POS_W-1:0] byte_position;
  logic        magic_good;
  logic        version_good;
  logic [7:0]  type_held;
  logic [7:0]  flags_held;
  logic [15:0] sequence_held;
  logic [15:0] length_held;
  logic [15:0] crc_running;
  logic [15:0] crc_received;

  logic [fdc_pkg::POS_W-1:0] byte_position_next;
  logic        magic_good_next;
  logic        version_good_next;
  logic [7:0]  type_held_next;
  logic [7:0]  flags_held_next;
  logic [15:0] sequence_held_next;
  logic [15:0] length_held_next;
  logic [15:0] crc_running_next;
  logic [15:0] crc_received_next;

  logic        fire;
  logic [15:0] crc_base;
  logic [fdc_pkg::POS_W-1:0] pay_off;
  logic        in_payload;
  logic [17:0] total;
  logic [17:0] expect_len;
  logic [15:0] limit;
  logic [2:0]  code;
  logic [7:0]  mapped_type;
  fdc_pkg::result_t pay_res;
  fdc_pkg::result_t stat_res;

  assign fire     = held_valid && room;
  assign in_ready = !held_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
      held_last <= in_last;
    end
  end

  always_comb begin
    crc_base           = (byte_position == fdc_pkg::POS_MAGIC0) ? cfg.crc_seed : crc_running;
    magic_good_next    = magic_good;
    version_good_next  = version_good;
    type_held_next     = type_held;
    flags_held_next    = flags_held;
    sequence_held_next = sequence_held;
    length_held_next   = length_held;
    crc_received_next  = crc_received;

    unique case (byte_position)
      fdc_pkg::POS_MAGIC0:  magic_good_next = magic_good && (held_byte == cfg.magic_first);
      fdc_pkg::POS_MAGIC1:  magic_good_next = magic_good && (held_byte == cfg.magic_second);
      fdc_pkg::POS_VERSION: version_good_next = (held_byte == cfg.protocol_version);
      fdc_pkg::POS_TYPE:    type_held_next = held_byte;
      fdc_pkg::POS_FLAGS:   flags_held_next = held_byte;
      fdc_pkg::POS_SEQ_LO:  sequence_held_next = {sequence_held[15:8], held_byte};
      fdc_pkg::POS_SEQ_HI:  sequence_held_next = {held_byte, sequence_held[7:0]};
      fdc_pkg::POS_LEN_LO:  length_held_next = {length_held[15:8], held_byte};
      fdc_pkg::POS_LEN_HI:  length_held_next = {held_byte, length_held[7:0]};
      fdc_pkg::POS_CRC_LO:  crc_received_next = {crc_received[15:8], held_byte};
      fdc_pkg::POS_CRC_HI:  crc_received_next = {held_byte, crc_received[7:0]};
      default: ;
    endcase

    pay_off    = byte_position - fdc_pkg::HDR_LEN;
    in_payload = (byte_position >= fdc_pkg::HDR_LEN) && (pay_off < {1'b0, length_held});

    // skip bytes past the declared length and the received CRC
    if (byte_position < fdc_pkg::CRC_SPAN || in_payload) begin
      crc_running_next = fdc_pkg::crc16_byte(crc_base, held_byte);
    end else begin
      crc_running_next = crc_base;
    end

    byte_position_next = (byte_position == fdc_pkg::POS_MAX) ?
                         byte_position : byte_position + 1'b1;

    total      = {1'b0, byte_position} + 18'd1;
    expect_len = 18'(fdc_pkg::HDR_LEN) + {2'b00, length_held_next};
    limit      = (cfg.max_payload_len > MaxLen) ? MaxLen : cfg.max_payload_len;

    if (total < 18'(fdc_pkg::HDR_LEN))             code = fdc_pkg::ST_TOO_SHORT;
    else if (!magic_good_next)                     code = fdc_pkg::ST_BAD_MAGIC;
    else if (!version_good_next)                   code = fdc_pkg::ST_BAD_VER;
    else if (length_held_next > limit)             code = fdc_pkg::ST_TOO_LARGE;
    else if (total < expect_len)                   code = fdc_pkg::ST_TOO_SHORT;
    else if (total > expect_len)                   code = fdc_pkg::ST_TOO_LARGE;
    else if (crc_running_next != crc_received_next) code = fdc_pkg::ST_CRC_ERR;
    else                                           code = fdc_pkg::ST_OK;

    if (type_held_next[7:6] == 2'b00 && cfg.known_type_mask[type_held_next[5:0]]) begin
      mapped_type = type_held_next;
    end else begin
      mapped_type = cfg.unknown_type_code;
    end

    pay_res                 = '0;
    pay_res.result_kind     = fdc_pkg::KIND_PAYLOAD;
    pay_res.payload_value   = held_byte;
    pay_res.payload_offset  = pay_off[15:0];
    pay_res.run_last        = !held_last;

    stat_res                 = '0;
    stat_res.result_kind     = fdc_pkg::KIND_STATUS;
    stat_res.status_code     = code;
    stat_res.frame_type      = mapped_type;
    stat_res.frame_flags     = flags_held_next;
    stat_res.sequence_number = sequence_held_next;
    stat_res.payload_count   = length_held_next;
    stat_res.run_last        = 1'b1;

    push_a = fire && (in_payload || held_last);
    res_a  = in_payload ? pay_res : stat_res;
    push_b = fire && in_payload && held_last;
    res_b  = stat_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      magic_good    <= 1'b1;
      version_good  <= 1'b1;
      type_held     <= 8'h00;
      flags_held    <= 8'h00;
      sequence_held <= 16'h0000;
      length_held   <= 16'h0000;
      crc_received  <= 16'h0000;
    end else if (fire) begin
      if (held_last) begin
        // restart at the next frame
        byte_position <= '0;
        magic_good    <= 1'b1;
        version_good  <= 1'b1;
        type_held     <= 8'h00;
        flags_held    <= 8'h00;
        sequence_held <= 16'h0000;
        length_held   <= 16'h0000;
        crc_received  <= 16'h0000;
      end else begin
        byte_position <= byte_position_next;
        magic_good    <= magic_good_next;
        version_good  <= version_good_next;
        type_held     <= type_held_next;
        flags_held    <= flags_held_next;
        sequence_held <= sequence_held_next;
        length_held   <= length_held_next;
        crc_received  <= crc_received_next;
      end
    end
  end

  // seed is reloaded at byte zero, so the running value needs no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      crc_running <= crc_running_next;
    end
  end

endmodule

@@ hw/rtl/fdc_out_queue.sv @@
module fdc_out_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_a,
  input  fdc_pkg::result_t             res_a,
  input  logic                         push_b,
  input  fdc_pkg::result_t             res_b,
  output logic                         room,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [fdc_pkg::DATA_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser
);

  localparam int unsigned Depth = 3;

  fdc_pkg::result_t q [Depth];
  fdc_pkg::result_t q_next [Depth];
  logic [1:0] occ;
  logic [1:0] occ_next;
  logic [1:0] base;
  logic       pop;
  fdc_pkg::result_t head;

  // room only depends on registered occupancy, which keeps the ready paths apart
  assign room          = (occ <= 2'd1);
  assign m_axis_tvalid = (occ != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head          = q[0];

  always_comb begin
    base     = occ - {1'b0, pop};
    occ_next = base + {1'b0, push_a} + {1'b0, push_b};
    for (int i = 0; i < Depth; i++) begin
      if (2'(i) < base) begin
        q_next[i] = (pop && i < Depth - 1) ? q[(i + 1) % Depth] : q[i];
      end else if (2'(i) == base && push_a) begin
        q_next[i] = res_a;
      end else if (2'(i) == base + 2'd1 && push_b) begin
        q_next[i] = res_b;
      end else begin
        q_next[i] = q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 2'd0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign m_axis_tdata = {5'b00000, head.payload_count, head.sequence_number, head.frame_flags,
                         head.frame_type, head.status_code, head.payload_offset,
                         head.payload_value};
  assign m_axis_tlast = head.run_last;
  assign m_axis_tuser = head.result_kind;

endmodule

@@ hw/rtl/frame_decoder_crc16_check_unit.sv @@
// Channel     | Dir | Transaction contents
// ------------+-----+---------------------------------------------------------------
// s_axis      | in  | tdata[7:0] data_byte; tlast end_of_buffer
// m_axis      | out | tdata payload_value, payload_offset, status_code, frame_type,
//             |     |   frame_flags, sequence_number, payload_count; tuser result_kind;
//             |     |   tlast run_last
// cfg         | in  | cfg_index register index 0..6, cfg_data value (always ready)
//
// One byte per cycle unless stalled; a byte is registered, then its result is queued.
// The end byte of a frame carrying a payload byte yields two results, so the output
// queue (three entries) sets the rate when the sink stalls; input stalls once occupancy
// reaches two. Synchronous reset clears frame state, the queue and registers to defaults.
module frame_decoder_crc16_check_unit #(
  parameter int unsigned MAX_PAYLOAD = fdc_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] payload_value, [23:8] payload_offset, [26:24] status_code,
  // [34:27] frame_type, [42:35] frame_flags, [58:43] sequence_number,
  // [74:59] payload_count, [79:75] zero
  output logic [fdc_pkg::DATA_W-1:0]      m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser,  // [0] result_kind
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fdc_pkg::cfg_t    cfg;
  logic             room;
  logic             push_a;
  logic             push_b;
  fdc_pkg::result_t res_a;
  fdc_pkg::result_t res_b;

  fdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdc_decoder #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dec (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .room     (room),
    .push_a   (push_a),
    .res_a    (res_a),
    .push_b   (push_b),
    .res_b    (res_b)
  );

  fdc_out_queue u_q (
    .clk           (clk),
    .rst           (rst),
    .push_a        (push_a),
    .res_a         (res_a),
    .push_b        (push_b),
    .res_b         (res_b),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ hw/rtl/fdc_checker.sv @@
module fdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fdc_pkg::DATA_W-1:0]    m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser
);

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("status result without tlast");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[fdc_pkg::DATA_W-1:24] == '0)
    else $error("payload result carries status fields");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:0] == 24'h0 &&
    m_axis_tdata[26:24] <= 3'd5)
    else $error("status result malformed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind frame_decoder_crc16_check_unit fdc_checker u_fdc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
